>>> sv/assert_macros.svh
// assertion macros for the rtl; the overlap test unit includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TBOT_ASSERT_IMPL(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tbot check failed");
// next-cycle implication
`define TBOT_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tbot check failed");
`else
`define TBOT_ASSERT_IMPL(name, pre, post)
`define TBOT_ASSERT_NEXT(name, pre, post)
`endif
`endif

>>> sv/tbot_pkg.sv
package tbot_pkg;
    localparam int HALF_BITS    = 31;
    localparam int CFG_IDX_BITS = 2;
    localparam int NUM_STAGES   = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_Z = 2'd2;
endpackage

>>> sv/tbot_if.sv
interface tbot_in_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic signed [COORD_BITS-1:0] a_x;
    logic signed [COORD_BITS-1:0] a_y;
    logic signed [COORD_BITS-1:0] a_z;
    logic signed [COORD_BITS-1:0] b_x;
    logic signed [COORD_BITS-1:0] b_y;
    logic signed [COORD_BITS-1:0] b_z;
    logic signed [COORD_BITS-1:0] c_x;
    logic signed [COORD_BITS-1:0] c_y;
    logic signed [COORD_BITS-1:0] c_z;

    modport source (output valid, center_x, center_y, center_z, a_x, a_y, a_z,
                    b_x, b_y, b_z, c_x, c_y, c_z, input ready);
    modport sink   (input valid, center_x, center_y, center_z, a_x, a_y, a_z,
                    b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tbot_out_if;
    logic valid;
    logic ready;
    logic overlaps;

    modport source (output valid, overlaps, input ready);
    modport sink   (input valid, overlaps, output ready);
endinterface

>>> sv/triangle_box_overlap_test_unit.sv
// channel  | dir | beat contents
// ---------+-----+--------------------------------------------------
// item     | in  | box center and three triangle vertices, Q16.16
// result   | out | overlaps flag
// cfg      | in  | half_x / half_y / half_z write, no handshake
//
// eight register stages; one beat enters per cycle while result is not
// stalled, and the flag is registered in the last stage
// the rate is set by the pipeline itself: every stage holds one multiply
// or one add and compare level, and all stages advance together
// a stall on result freezes every stage and drops item ready in the
// same cycle, so nothing is lost or repeated
// rst_n clears the stage valid bits and the half-extents to zero
`include "assert_macros.svh"

module triangle_box_overlap_test_unit
    import tbot_pkg::*;
#(
    parameter int COORD_BITS = 32
)(
    input  logic                    clk,
    input  logic                    rst_n,
    tbot_in_if.sink                 item,
    tbot_out_if.source              result,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [HALF_BITS-1:0]    cfg_data
);
    // relative vertex, edge, edge-axis product and sum widths
    localparam int VW  = COORD_BITS + 1;
    localparam int EW  = COORD_BITS + 2;
    localparam int PW  = EW + VW;
    localparam int QW  = PW + 1;
    localparam int RPW = EW + HALF_BITS;
    localparam int RW  = RPW + 1;
    localparam int GW  = ((QW > RW + 1) ? QW : RW + 1) + 1;
    localparam int AW  = ((VW > HALF_BITS + 1) ? VW : HALF_BITS + 1) + 1;
    // plane normal and split products
    localparam int NPW = 2 * EW;
    localparam int NW  = NPW + 1;
    localparam int SPL = NW / 2;
    localparam int NHW = NW - SPL;
    localparam int SMW = NW + VW;
    localparam int SW  = SMW + 2;
    localparam int RTW = NW + HALF_BITS;
    localparam int RSW = RTW + 2;
    localparam int FW  = ((SW > RSW + 1) ? SW : RSW + 1) + 1;

    // half-extent registers
    logic [HALF_BITS-1:0] half_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg[0] <= '0;
            half_reg[1] <= '0;
            half_reg[2] <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HALF_X: half_reg[0] <= cfg_data;
                CFG_HALF_Y: half_reg[1] <= cfg_data;
                CFG_HALF_Z: half_reg[2] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // pipeline advance: all stages move unless the last one is stuck
    logic                  en;
    logic [NUM_STAGES-1:0] vld_reg;

    assign en           = !vld_reg[NUM_STAGES-1] || result.ready;
    assign item.ready   = en;
    assign result.valid = vld_reg[NUM_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], item.valid};
    end

    // input unpacking
    logic signed [COORD_BITS-1:0] ctr [3];
    logic signed [COORD_BITS-1:0] vtx [3][3];

    assign ctr[0] = item.center_x;
    assign ctr[1] = item.center_y;
    assign ctr[2] = item.center_z;
    assign vtx[0][0] = item.a_x;
    assign vtx[0][1] = item.a_y;
    assign vtx[0][2] = item.a_z;
    assign vtx[1][0] = item.b_x;
    assign vtx[1][1] = item.b_y;
    assign vtx[1][2] = item.b_z;
    assign vtx[2][0] = item.c_x;
    assign vtx[2][1] = item.c_y;
    assign vtx[2][2] = item.c_z;

    // stage 1: vertices relative to the box center
    logic signed [VW-1:0] v1_reg [3][3];
    logic signed [VW-1:0] v1_next [3][3];
    // stage 2: edges, coordinate axis test
    logic signed [VW-1:0] v2_reg [3][3];
    logic signed [EW-1:0] e2_reg [3][3];
    logic signed [EW-1:0] e2_next [3][3];
    logic                 ok2_reg;
    logic                 ok2_next;
    logic [2:0]           axsep;
    // stage 3: edge-axis, radius and normal products
    logic signed [PW-1:0]  ep3_reg [3][3][2][2];
    logic signed [PW-1:0]  ep3_next [3][3][2][2];
    logic [RPW-1:0]        rp3_reg [3][3][2];
    logic [RPW-1:0]        rp3_next [3][3][2];
    logic signed [NPW-1:0] np3_reg [3][2];
    logic signed [NPW-1:0] np3_next [3][2];
    logic signed [VW-1:0]  v3_reg [3];
    logic                  ok3_reg;
    // stage 4: projections, radii, plane normal
    logic signed [QW-1:0] pj4_reg [3][3][2];
    logic signed [QW-1:0] pj4_next [3][3][2];
    logic [RW-1:0]        rd4_reg [3][3];
    logic [RW-1:0]        rd4_next [3][3];
    logic signed [NW-1:0] n4_reg [3];
    logic signed [NW-1:0] n4_next [3];
    logic signed [VW-1:0] v4_reg [3];
    logic                 ok4_reg;
    // stage 5: edge-axis verdict, plane split products
    logic [8:0]                  edsep;
    logic                        ok5_reg;
    logic signed [NHW+VW-1:0]    sh5_reg [3];
    logic signed [NHW+VW-1:0]    sh5_next [3];
    logic signed [SPL+VW:0]      sl5_reg [3];
    logic signed [SPL+VW:0]      sl5_next [3];
    logic [NHW+HALF_BITS-1:0]    rh5_reg [3];
    logic [NHW+HALF_BITS-1:0]    rh5_next [3];
    logic [SPL+HALF_BITS-1:0]    rl5_reg [3];
    logic [SPL+HALF_BITS-1:0]    rl5_next [3];
    // stage 6: plane terms
    logic signed [SMW-1:0] st6_reg [3];
    logic signed [SMW-1:0] st6_next [3];
    logic [RTW-1:0]        rt6_reg [3];
    logic [RTW-1:0]        rt6_next [3];
    logic                  ok6_reg;
    // stage 7: plane sums
    logic signed [SW-1:0] s7_reg;
    logic [RSW-1:0]       r7_reg;
    logic                 ok7_reg;
    // stage 8: result
    logic                 ovl8_reg;
    logic signed [FW-1:0] s_cmp;
    logic signed [FW-1:0] r_cmp;

    genvar k, i, m;
    generate
        for (k = 0; k < 3; k++)
        begin : g_vtx
            for (i = 0; i < 3; i++)
            begin : g_cmp
                assign v1_next[k][i] = VW'(vtx[k][i]) - VW'(ctr[i]);
                assign e2_next[k][i] = EW'(v1_reg[(k + 1) % 3][i]) - EW'(v1_reg[k][i]);
            end
        end

        for (i = 0; i < 3; i++)
        begin : g_axis
            logic signed [AW-1:0] hv;
            assign hv = $signed(AW'(half_reg[i]));
            assign axsep[i] =
                (AW'(v1_reg[0][i]) > hv && AW'(v1_reg[1][i]) > hv && AW'(v1_reg[2][i]) > hv) ||
                (AW'(v1_reg[0][i]) < -hv && AW'(v1_reg[1][i]) < -hv &&
                 AW'(v1_reg[2][i]) < -hv);
        end

        // edge k crossed with unit axis i; endpoint vertex k and opposite vertex
        for (k = 0; k < 3; k++)
        begin : g_edge
            for (i = 0; i < 3; i++)
            begin : g_ax
                localparam int CA = (i + 1) % 3;
                localparam int CB = (i + 2) % 3;
                logic [EW-1:0]        ea;
                logic [EW-1:0]        eb;
                logic signed [GW-1:0] rr;
                assign ea = e2_reg[k][CA][EW-1] ? EW'(-e2_reg[k][CA]) : e2_reg[k][CA];
                assign eb = e2_reg[k][CB][EW-1] ? EW'(-e2_reg[k][CB]) : e2_reg[k][CB];
                assign rp3_next[k][i][0] = RPW'(eb) * RPW'(half_reg[CA]);
                assign rp3_next[k][i][1] = RPW'(ea) * RPW'(half_reg[CB]);
                for (m = 0; m < 2; m++)
                begin : g_vs
                    localparam int VI = (m == 0) ? k : (k + 2) % 3;
                    assign ep3_next[k][i][m][0] = PW'(e2_reg[k][CB]) * PW'(v2_reg[VI][CA]);
                    assign ep3_next[k][i][m][1] = PW'(e2_reg[k][CA]) * PW'(v2_reg[VI][CB]);
                    assign pj4_next[k][i][m] = QW'(ep3_reg[k][i][m][0]) -
                                               QW'(ep3_reg[k][i][m][1]);
                end
                assign rd4_next[k][i] = RW'(rp3_reg[k][i][0]) + RW'(rp3_reg[k][i][1]);
                assign rr = $signed(GW'(rd4_reg[k][i]));
                assign edsep[3*k+i] =
                    (GW'(pj4_reg[k][i][0]) > rr && GW'(pj4_reg[k][i][1]) > rr) ||
                    (GW'(pj4_reg[k][i][0]) < -rr && GW'(pj4_reg[k][i][1]) < -rr);
            end
        end

        // plane normal n = e0 x e1, then split products against v0 and h
        for (i = 0; i < 3; i++)
        begin : g_plane
            localparam int CA = (i + 1) % 3;
            localparam int CB = (i + 2) % 3;
            logic [NW-1:0] na;
            assign np3_next[i][0] = NPW'(e2_reg[0][CA]) * NPW'(e2_reg[1][CB]);
            assign np3_next[i][1] = NPW'(e2_reg[0][CB]) * NPW'(e2_reg[1][CA]);
            assign n4_next[i] = NW'(np3_reg[i][0]) - NW'(np3_reg[i][1]);
            assign na = n4_reg[i][NW-1] ? NW'(-n4_reg[i]) : n4_reg[i];
            assign sh5_next[i] = (NHW+VW)'($signed(n4_reg[i][NW-1:SPL])) *
                                 (NHW+VW)'(v4_reg[i]);
            assign sl5_next[i] = (SPL+VW+1)'($signed({1'b0, n4_reg[i][SPL-1:0]})) *
                                 (SPL+VW+1)'(v4_reg[i]);
            assign rh5_next[i] = (NHW+HALF_BITS)'(na[NW-1:SPL]) *
                                 (NHW+HALF_BITS)'(half_reg[i]);
            assign rl5_next[i] = (SPL+HALF_BITS)'(na[SPL-1:0]) *
                                 (SPL+HALF_BITS)'(half_reg[i]);
            assign st6_next[i] = (SMW'(sh5_reg[i]) <<< SPL) + SMW'(sl5_reg[i]);
            assign rt6_next[i] = (RTW'(rh5_reg[i]) << SPL) + RTW'(rl5_reg[i]);
        end
    endgenerate

    assign ok2_next = !(|axsep);
    assign s_cmp    = FW'(s7_reg);
    assign r_cmp    = $signed(FW'(r7_reg));

    // payload registers, frozen while stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v1_reg   <= v1_next;
            v2_reg   <= v1_reg;
            e2_reg   <= e2_next;
            ok2_reg  <= ok2_next;
            ep3_reg  <= ep3_next;
            rp3_reg  <= rp3_next;
            np3_reg  <= np3_next;
            v3_reg   <= v2_reg[0];
            ok3_reg  <= ok2_reg;
            pj4_reg  <= pj4_next;
            rd4_reg  <= rd4_next;
            n4_reg   <= n4_next;
            v4_reg   <= v3_reg;
            ok4_reg  <= ok3_reg;
            ok5_reg  <= ok4_reg && !(|edsep);
            sh5_reg  <= sh5_next;
            sl5_reg  <= sl5_next;
            rh5_reg  <= rh5_next;
            rl5_reg  <= rl5_next;
            st6_reg  <= st6_next;
            rt6_reg  <= rt6_next;
            ok6_reg  <= ok5_reg;
            s7_reg   <= SW'(st6_reg[0]) + SW'(st6_reg[1]) + SW'(st6_reg[2]);
            r7_reg   <= RSW'(rt6_reg[0]) + RSW'(rt6_reg[1]) + RSW'(rt6_reg[2]);
            ok7_reg  <= ok6_reg;
            // plane accepts only when -r <= s < r
            ovl8_reg <= ok7_reg && (s_cmp >= -r_cmp) && (s_cmp < r_cmp);
        end
    end

    assign result.overlaps = ovl8_reg;

    `TBOT_ASSERT_NEXT(a_stall_holds, !en, vld_reg == $past(vld_reg))
    `TBOT_ASSERT_NEXT(a_take_enters, item.valid && item.ready, vld_reg[0])
    `TBOT_ASSERT_NEXT(a_cfg_ignored, cfg_we && cfg_index > CFG_HALF_Z, $stable(half_reg[0]) && $stable(half_reg[1]) && $stable(half_reg[2]))
    `TBOT_ASSERT_IMPL(a_ready_when_empty, !vld_reg[NUM_STAGES-1], item.ready)
endmodule

>>> dv/testbench.sv
module testbench;
    import tbot_pkg::*;

    typedef logic signed [159:0] wide_t;
    // center x/y/z, then vertex a, b, c, each x/y/z
    typedef logic signed [31:0] tri_t [12];

    // expected overlap flags, oldest first, with a mismatch count
    class overlap_board;
        bit flags[$];
        int errors;
        int seen;
        int hits;

        function void note(bit flag);
            flags.push_back(flag);
        endfunction

        function void check(logic got);
            bit want;
            seen++;
            if (flags.size() == 0)
            begin
                $error("overlaps: no beat expected, actual %b", got);
                errors++;
                return;
            end
            want = flags.pop_front();
            if (got === 1'b1)
                hits++;
            if (got !== want)
            begin
                $error("overlaps: expected %b, actual %b", want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [HALF_BITS-1:0] cfg_data;

    tbot_in_if #(.COORD_BITS(32)) item_if();
    tbot_out_if result_if();

    triangle_box_overlap_test_unit #(.COORD_BITS(32)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_if.sink),
        .result(result_if.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    overlap_board board = new();
    logic [HALF_BITS-1:0] half_ext [3];
    int items_sent;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // projection range of the three vertices on axis n against box radius
    function automatic bit axis_separates(wide_t n [3], wide_t v [3][3], wide_t h [3]);
        wide_t p;
        wide_t lo;
        wide_t hi;
        wide_t rad;
        lo = 0;
        hi = 0;
        rad = 0;
        for (int i = 0; i < 3; i++)
            rad += ((n[i] < 0) ? -n[i] : n[i]) * h[i];
        for (int k = 0; k < 3; k++)
        begin
            p = n[0] * v[k][0] + n[1] * v[k][1] + n[2] * v[k][2];
            if (k == 0 || p < lo)
                lo = p;
            if (k == 0 || p > hi)
                hi = p;
        end
        return (lo > rad) || (hi < -rad);
    endfunction

    // exact separating axis test at full width
    function automatic bit tri_box_overlap(tri_t t);
        wide_t v [3][3];
        wide_t e [3][3];
        wide_t h [3];
        wide_t n [3];
        wide_t s;
        wide_t rad;
        for (int i = 0; i < 3; i++)
        begin
            h[i] = 0;
            h[i][HALF_BITS-1:0] = half_ext[i];
            for (int k = 0; k < 3; k++)
                v[k][i] = wide_t'(t[3 + 3 * k + i]) - wide_t'(t[i]);
        end
        // coordinate axes
        for (int i = 0; i < 3; i++)
        begin
            n[0] = 0;
            n[1] = 0;
            n[2] = 0;
            n[i] = 1;
            if (axis_separates(n, v, h))
                return 1'b0;
        end
        for (int i = 0; i < 3; i++)
        begin
            e[0][i] = v[1][i] - v[0][i];
            e[1][i] = v[2][i] - v[1][i];
            e[2][i] = v[0][i] - v[2][i];
        end
        // triangle plane: near corner must not be above, far corner strictly above
        n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
        n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
        n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
        s = n[0] * v[0][0] + n[1] * v[0][1] + n[2] * v[0][2];
        rad = 0;
        for (int i = 0; i < 3; i++)
            rad += ((n[i] < 0) ? -n[i] : n[i]) * h[i];
        if (s < -rad || s >= rad)
            return 1'b0;
        // edge cross axis tests, each edge against each coordinate axis
        for (int k = 0; k < 3; k++)
        begin
            n[0] = 0;
            n[1] = e[k][2];
            n[2] = -e[k][1];
            if (axis_separates(n, v, h))
                return 1'b0;
            n[0] = -e[k][2];
            n[1] = 0;
            n[2] = e[k][0];
            if (axis_separates(n, v, h))
                return 1'b0;
            n[0] = e[k][1];
            n[1] = -e[k][0];
            n[2] = 0;
            if (axis_separates(n, v, h))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // one config write, index above 2 is dropped by the block
    task automatic write_half(logic [CFG_IDX_BITS-1:0] idx, logic [HALF_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HALF_X)
            half_ext[0] = val;
        else if (idx == CFG_HALF_Y)
            half_ext[1] = val;
        else if (idx == CFG_HALF_Z)
            half_ext[2] = val;
    endtask

    task automatic set_box(logic [HALF_BITS-1:0] hx, logic [HALF_BITS-1:0] hy,
                           logic [HALF_BITS-1:0] hz);
        write_half(CFG_HALF_X, hx);
        write_half(CFG_HALF_Y, hy);
        write_half(CFG_HALF_Z, hz);
    endtask

    // wait until every flag is back, then let the pipe run empty
    task automatic drain();
        while (board.flags.size() != 0)
            @(posedge clk);
        repeat (NUM_STAGES + 4) @(posedge clk);
    endtask

    // hold one beat until taken; valid stays high for the next beat
    task automatic send_item(tri_t t);
        item_if.valid <= 1'b1;
        item_if.center_x <= t[0];
        item_if.center_y <= t[1];
        item_if.center_z <= t[2];
        item_if.a_x <= t[3];
        item_if.a_y <= t[4];
        item_if.a_z <= t[5];
        item_if.b_x <= t[6];
        item_if.b_y <= t[7];
        item_if.b_z <= t[8];
        item_if.c_x <= t[9];
        item_if.c_y <= t[10];
        item_if.c_z <= t[11];
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        board.note(tri_box_overlap(t));
        items_sent++;
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // triangle from three vertex offsets, in Q16.16, from a given center
    function automatic tri_t make_tri(int cx, int cy, int cz, int ax, int ay, int az,
                                      int bx, int by, int bz, int qx, int qy, int qz);
        tri_t t;
        t[0] = cx;
        t[1] = cy;
        t[2] = cz;
        t[3] = cx + ax;
        t[4] = cy + ay;
        t[5] = cz + az;
        t[6] = cx + bx;
        t[7] = cy + by;
        t[8] = cz + bz;
        t[9] = cx + qx;
        t[10] = cy + qy;
        t[11] = cz + qz;
        return t;
    endfunction

    // mostly triangles near the box so every test stage gets exercised,
    // the rest fully random words
    function automatic tri_t random_tri(int span);
        tri_t t;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            t[i] = $urandom();
        if (kind >= 3)
        begin
            for (int i = 3; i < 12; i++)
                t[i] = t[i % 3] + $signed($urandom_range(0, 2 * span)) - span;
            // collapsed triangles now and then
            if (kind == 9)
            begin
                t[9] = t[6];
                t[10] = t[7];
                t[11] = t[8];
            end
        end
        return t;
    endfunction

    // receiver: long fully-ready stretches alternate with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
        end
        else
        begin
            if (($time / 640) % 3 == 0)
                result_if.ready <= 1'b1;
            else
                result_if.ready <= ($urandom_range(0, 99) < 65);
        end
    end

    // result beats are checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
            board.check(result_if.overlaps);
    end

    initial
    begin
        #3000000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin
        logic [HALF_BITS-1:0] box [6][3];
        tri_t t;
        int burst;
        int span;
        int one;

        one = 32'sh0001_0000;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        item_if.valid = 1'b0;
        item_if.center_x = '0;
        item_if.center_y = '0;
        item_if.center_z = '0;
        item_if.a_x = '0;
        item_if.a_y = '0;
        item_if.a_z = '0;
        item_if.b_x = '0;
        item_if.b_y = '0;
        item_if.b_z = '0;
        item_if.c_x = '0;
        item_if.c_y = '0;
        item_if.c_z = '0;
        for (int i = 0; i < 3; i++)
            half_ext[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with a unit box
        set_box(31'h0001_0000, 31'h0001_0000, 31'h0001_0000);
        // write to an unused index must leave the box alone
        write_half(2'd3, '1);
        // triangle through the center overlaps
        send_item(make_tri(0, 0, 0, -one, -one, 0, one, -one, 0, 0, one, 0));
        // far out along x, y, z: coordinate axis rejects
        send_item(make_tri(0, 0, 0, 3*one, 0, 0, 4*one, one, 0, 3*one, one, one));
        send_item(make_tri(0, 0, 0, 0, -3*one, 0, one, -4*one, 0, 0, -3*one, one));
        send_item(make_tri(0, 0, 0, 0, 0, 2*one, one, 0, 2*one, 0, one, 2*one));
        // slanted plane clears a corner while the axes still overlap
        send_item(make_tri(0, 0, 0, 3*one, 0, 0, 0, 3*one, 0, 0, 0, 3*one));
        send_item(make_tri(0, 0, 0, 2*one, 0, 0, 0, 2*one, 0, 0, 0, 2*one));
        // plane exactly touching a face: far corner value not strictly above
        send_item(make_tri(0, 0, 0, -one, -one, one, one, -one, one, 0, one, one));
        // edge cross axis separates: long thin sliver past a box edge
        send_item(make_tri(0, 0, 0, 2*one, -one/2, -one, -one/2, 2*one, -one, 2*one, -one/2, one));
        // degenerate triangles: repeated vertex and all at one point
        send_item(make_tri(0, 0, 0, -one, 0, 0, one, 0, 0, one, 0, 0));
        send_item(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // field extremes
        for (int i = 0; i < 12; i++)
            t[i] = 32'sh8000_0000;
        send_item(t);
        for (int i = 0; i < 12; i++)
            t[i] = 32'sh7FFF_FFFF;
        send_item(t);
        for (int i = 0; i < 12; i++)
            t[i] = (i % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        send_item(t);
        for (int i = 0; i < 12; i++)
            t[i] = (i < 3) ? 32'sh8000_0000 : ((i % 3 == 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        send_item(t);
        idle_gap(1);
        drain();

        // random phases over several box shapes, extremes included
        box[0] = '{31'd0, 31'd0, 31'd0};
        box[1] = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
        box[2] = '{31'h0001_0000, 31'h0002_0000, 31'h0000_8000};
        box[3] = '{31'h0000_0000, 31'h0004_0000, 31'h7FFF_FFFF};
        box[4] = '{HALF_BITS'($urandom_range(1, 32'h000F_FFFF)),
                   HALF_BITS'($urandom_range(1, 32'h000F_FFFF)),
                   HALF_BITS'($urandom_range(1, 32'h000F_FFFF))};
        box[5] = '{HALF_BITS'($urandom()), HALF_BITS'($urandom()), HALF_BITS'($urandom())};
        for (int p = 0; p < 6; p++)
        begin
            set_box(box[p][0], box[p][1], box[p][2]);
            span = 3 * int'((box[p][0] > 31'h0010_0000) ? 31'h0010_0000 : box[p][0]);
            if (span < 4 * one)
                span = 4 * one;
            while (items_sent < 14 + (p + 1) * 300)
            begin
                burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 12);
                for (int b = 0; b < burst; b++)
                    send_item(random_tri(span));
                idle_gap($urandom_range(0, 6));
            end
            idle_gap(1);
            drain();
        end

        $display("sent %0d triangle/box pairs over 7 box settings, %0d results, %0d overlaps",
                 items_sent, board.seen, board.hits);
        $display("covered axis, plane, edge cross and degenerate cases with random stalls");
        if (board.errors == 0 && board.flags.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
